[hdl/tfc_pkg.sv]
// ----------------------------------------------------------------------------
// tfc_pkg
// Shared widths, operation codes and types for the timecode and frame count
// converter.
// ----------------------------------------------------------------------------
package tfc_pkg;

   localparam int RATE_W             = 18;
   localparam int RATE_RESET         = 25000;
   localparam int FIELD_W            = 8;
   localparam int OP_W               = 2;
   localparam int COUNT_BITS_DEFAULT = 31;

   // Divisor widths: frames per hour, per minute and per second at the
   // highest rate the register can hold.
   localparam int PH_W = 20;
   localparam int PM_W = 14;
   localparam int PS_W = 9;

   // Result field widths.
   localparam int HOURS_W = 20;
   localparam int MIN_W   = 6;
   localparam int SEC_W   = 6;
   localparam int FRM_W   = 8;

   // Quotient widths of the minute and second dividers.
   localparam int MQ_W = 7;
   localparam int SQ_W = 7;

   typedef enum logic [OP_W-1:0] {
      OP_TO_FIELDS = 2'd0,
      OP_FROM_BIN  = 2'd1,
      OP_FROM_BCD  = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      RP_IDLE,
      RP_MUL,
      RP_FIX
   } rate_phase_type;

   typedef struct packed {
      logic [RATE_W-1:0] rate;
      logic [PH_W-1:0]   per_hour;
      logic [PM_W-1:0]   per_min;
      logic [PS_W-1:0]   per_sec;
      logic              busy;
   } rate_info_type;

endpackage

[hdl/tfc_rate_unit.sv]
// ----------------------------------------------------------------------------
// tfc_rate_unit
// Holds the frame rate register and derives the frames per hour, minute and
// second divisors from it after each write, in a multiply and a fix phase.
// ----------------------------------------------------------------------------
module tfc_rate_unit
   import tfc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [RATE_W-1:0]   csr_rate_milli_fps,
   output rate_info_type       info
);

   // Operand widths of rate*18, rate*3 and rate.
   localparam int XH_W = 23;
   localparam int XM_W = 20;
   localparam int XS_W = 18;
   localparam int RH_W = 21;
   localparam int RM_W = 15;
   localparam int RS_W = 9;
   localparam int RECIP_H = (1 << XH_W) / 5;
   localparam int RECIP_M = (1 << XM_W) / 50;
   localparam int RECIP_S = (1 << XS_W) / 1000;
   localparam int PH_RESET = RATE_RESET * 18 / 5;
   localparam int PM_RESET = RATE_RESET * 3 / 50;
   localparam int PS_RESET = RATE_RESET / 1000;

   rate_phase_type                 phase_ff, phase_in;
   logic [RATE_W-1:0]              rate_ff;
   logic [PH_W-1:0]                ph_ff;
   logic [PM_W-1:0]                pm_ff;
   logic [PS_W-1:0]                ps_ff;
   logic [XH_W+RH_W-1:0]           prod_h_ff;
   logic [XM_W+RM_W-1:0]           prod_m_ff;
   logic [XS_W+RS_W-1:0]           prod_s_ff;

   logic [XH_W-1:0] x_h;
   logic [XM_W-1:0] x_m;
   logic [XS_W-1:0] x_s;
   logic [RH_W-1:0] q0_h;
   logic [RM_W-1:0] q0_m;
   logic [RS_W-1:0] q0_s;
   logic [XH_W-1:0] rem_h;
   logic [XM_W-1:0] rem_m;
   logic [XS_W-1:0] rem_s;
   logic [RH_W-1:0] q_h;
   logic [RM_W-1:0] q_m;
   logic [RS_W-1:0] q_s;
   logic            write;

   assign write = csr_valid && csr_ready;

   assign x_h = XH_W'({rate_ff, 4'b0000}) + XH_W'({rate_ff, 1'b0});
   assign x_m = XM_W'({rate_ff, 1'b0}) + XM_W'(rate_ff);
   assign x_s = rate_ff;

   // The reciprocal estimate is low by at most one; one compare fixes it.
   always_comb begin
      q0_h  = prod_h_ff[XH_W+RH_W-1:XH_W];
      q0_m  = prod_m_ff[XM_W+RM_W-1:XM_W];
      q0_s  = prod_s_ff[XS_W+RS_W-1:XS_W];
      rem_h = x_h - XH_W'(XH_W'(q0_h) * XH_W'(5));
      rem_m = x_m - XM_W'(XM_W'(q0_m) * XM_W'(50));
      rem_s = x_s - XS_W'(XS_W'(q0_s) * XS_W'(1000));
      q_h   = (rem_h >= XH_W'(5))    ? q0_h + RH_W'(1) : q0_h;
      q_m   = (rem_m >= XM_W'(50))   ? q0_m + RM_W'(1) : q0_m;
      q_s   = (rem_s >= XS_W'(1000)) ? q0_s + RS_W'(1) : q0_s;
   end

   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         RP_IDLE: if (write) phase_in = RP_MUL;
         RP_MUL:  phase_in = RP_FIX;
         RP_FIX:  phase_in = RP_IDLE;
         default: phase_in = RP_IDLE;
      endcase
   end

   always_comb begin
      csr_ready     = (phase_ff == RP_IDLE);
      info.busy     = (phase_ff != RP_IDLE);
      info.rate     = rate_ff;
      info.per_hour = ph_ff;
      info.per_min  = pm_ff;
      info.per_sec  = ps_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= RP_IDLE;
         rate_ff  <= RATE_W'(RATE_RESET);
         ph_ff    <= PH_W'(PH_RESET);
         pm_ff    <= PM_W'(PM_RESET);
         ps_ff    <= PS_W'(PS_RESET);
      end else begin
         phase_ff <= phase_in;
         if (write) rate_ff <= csr_rate_milli_fps;
         if (phase_ff == RP_FIX) begin
            ph_ff <= PH_W'(q_h);
            pm_ff <= PM_W'(q_m);
            ps_ff <= PS_W'(q_s);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (phase_ff == RP_MUL) begin
         prod_h_ff <= (XH_W+RH_W)'(x_h) * (XH_W+RH_W)'(RECIP_H);
         prod_m_ff <= (XM_W+RM_W)'(x_m) * (XM_W+RM_W)'(RECIP_M);
         prod_s_ff <= (XS_W+RS_W)'(x_s) * (XS_W+RS_W)'(RECIP_S);
      end
   end

endmodule

[hdl/tfc_count_path.sv]
// ----------------------------------------------------------------------------
// tfc_count_path
// Five-stage pipeline that turns binary or BCD timecode fields into an
// absolute frame count at the configured rate.
// ----------------------------------------------------------------------------
module tfc_count_path
   import tfc_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEFAULT
)
(
   input  logic                  clock,
   input  logic                  adv,
   input  logic [RATE_W-1:0]     rate,
   input  logic [OP_W-1:0]       operation,
   input  logic [FIELD_W-1:0]    hours_in,
   input  logic [FIELD_W-1:0]    minutes_in,
   input  logic [FIELD_W-1:0]    seconds_in,
   input  logic [FIELD_W-1:0]    frames_in,
   output logic [COUNT_BITS-1:0] count_out
);

   localparam int HR_W  = FIELD_W + RATE_W;
   localparam int XH_W  = 31;
   localparam int XM_W  = 28;
   localparam int XS_W  = 26;
   localparam int RH_W  = 29;
   localparam int RM_W  = 23;
   localparam int RS_W  = 17;
   localparam longint unsigned RECIP_H = (64'd1 << XH_W) / 5;
   localparam longint unsigned RECIP_M = (64'd1 << XM_W) / 50;
   localparam longint unsigned RECIP_S = (64'd1 << XS_W) / 1000;
   localparam int SUM_W = 32;

   logic                  cnt0_ff, cnt1_ff, cnt2_ff, cnt3_ff;
   logic [FIELD_W-1:0]    h0_ff, m0_ff, s0_ff, f0_ff, f1_ff, f2_ff, f3_ff;
   logic [HR_W-1:0]       hr1_ff, mr1_ff, sr1_ff;
   logic [XH_W-1:0]       xh2_ff;
   logic [XM_W-1:0]       xm2_ff;
   logic [XS_W-1:0]       xs2_ff;
   logic [XH_W+RH_W-1:0]  ph2_ff;
   logic [XM_W+RM_W-1:0]  pm2_ff;
   logic [XS_W+RS_W-1:0]  ps2_ff;
   logic [RH_W-1:0]       qh3_ff;
   logic [RM_W-1:0]       qm3_ff;
   logic [RS_W-1:0]       qs3_ff;
   logic [COUNT_BITS-1:0] count_ff;

   logic                  is_bcd;
   logic [XH_W-1:0]       xh, rem_h;
   logic [XM_W-1:0]       xm, rem_m;
   logic [RH_W-1:0]       q0_h;
   logic [RM_W-1:0]       q0_m;
   logic [RS_W-1:0]       q0_s;
   logic [XS_W-1:0]       rem_s;
   logic [SUM_W-1:0]      sum;

   function automatic logic [FIELD_W-1:0] bcd_decode(input logic [FIELD_W-1:0] b);
      return FIELD_W'({4'b0000, b[7:4]} * 8'd10) + FIELD_W'(b[3:0]);
   endfunction

   assign is_bcd = (operation == OP_FROM_BCD);
   assign xh     = XH_W'({hr1_ff, 4'b0000}) + XH_W'({hr1_ff, 1'b0});
   assign xm     = XM_W'({mr1_ff, 1'b0}) + XM_W'(mr1_ff);

   always_comb begin
      q0_h  = ph2_ff[XH_W+RH_W-1:XH_W];
      q0_m  = pm2_ff[XM_W+RM_W-1:XM_W];
      q0_s  = ps2_ff[XS_W+RS_W-1:XS_W];
      rem_h = xh2_ff - XH_W'(XH_W'(q0_h) * XH_W'(5));
      rem_m = xm2_ff - XM_W'(XM_W'(q0_m) * XM_W'(50));
      rem_s = xs2_ff - XS_W'(XS_W'(q0_s) * XS_W'(1000));
      sum   = SUM_W'(qh3_ff) + SUM_W'(qm3_ff) + SUM_W'(qs3_ff) + SUM_W'(f3_ff);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cnt0_ff <= (operation == OP_FROM_BIN) || is_bcd;
         h0_ff   <= is_bcd ? bcd_decode(hours_in)   : hours_in;
         m0_ff   <= is_bcd ? bcd_decode(minutes_in) : minutes_in;
         s0_ff   <= is_bcd ? bcd_decode(seconds_in) : seconds_in;
         f0_ff   <= is_bcd ? bcd_decode(frames_in)  : frames_in;

         cnt1_ff <= cnt0_ff;
         hr1_ff  <= HR_W'(h0_ff) * HR_W'(rate);
         mr1_ff  <= HR_W'(m0_ff) * HR_W'(rate);
         sr1_ff  <= HR_W'(s0_ff) * HR_W'(rate);
         f1_ff   <= f0_ff;

         cnt2_ff <= cnt1_ff;
         xh2_ff  <= xh;
         xm2_ff  <= xm;
         xs2_ff  <= sr1_ff;
         ph2_ff  <= (XH_W+RH_W)'(xh) * (XH_W+RH_W)'(RECIP_H);
         pm2_ff  <= (XM_W+RM_W)'(xm) * (XM_W+RM_W)'(RECIP_M);
         ps2_ff  <= (XS_W+RS_W)'(sr1_ff) * (XS_W+RS_W)'(RECIP_S);
         f2_ff   <= f1_ff;

         cnt3_ff <= cnt2_ff;
         qh3_ff  <= (rem_h >= XH_W'(5))    ? q0_h + RH_W'(1) : q0_h;
         qm3_ff  <= (rem_m >= XM_W'(50))   ? q0_m + RM_W'(1) : q0_m;
         qs3_ff  <= (rem_s >= XS_W'(1000)) ? q0_s + RS_W'(1) : q0_s;
         f3_ff   <= f2_ff;

         if (!cnt3_ff)
            count_ff <= '0;
         else if ((sum >> COUNT_BITS) != '0)
            count_ff <= '1;
         else
            count_ff <= COUNT_BITS'(sum);
      end
   end

   assign count_out = count_ff;

endmodule

[hdl/timecode_frame_count_converter.sv]
// ----------------------------------------------------------------------------
// timecode_frame_count_converter
// Converts between absolute frame counts and non-drop timecode fields.
// ----------------------------------------------------------------------------
// One transaction may enter every cycle while the output skid register is
// empty and no rate update is running. The count to timecode split runs as a
// restoring divider with one quotient bit per stage, COUNT_BITS stages for
// hours, then seven each for minutes and seconds. The field to count
// direction runs in five stages alongside and is carried to the same output.
// A rate write keeps csr_ready and req_ready low while the new divisors are
// derived.
module timecode_frame_count_converter
   import tfc_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEFAULT
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [OP_W-1:0]       req_operation,
   input  logic [COUNT_BITS-1:0] req_frame_count_in,
   input  logic [FIELD_W-1:0]    req_hours_in,
   input  logic [FIELD_W-1:0]    req_minutes_in,
   input  logic [FIELD_W-1:0]    req_seconds_in,
   input  logic [FIELD_W-1:0]    req_frames_in,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [COUNT_BITS-1:0] rsp_frame_count_out,
   output logic [HOURS_W-1:0]    rsp_hours_out,
   output logic [MIN_W-1:0]      rsp_minutes_out,
   output logic [SEC_W-1:0]      rsp_seconds_out,
   output logic [FRM_W-1:0]      rsp_frames_out,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [RATE_W-1:0]     csr_rate_milli_fps
);

   localparam int STAGES    = COUNT_BITS + MQ_W + SQ_W;
   localparam int LAST      = STAGES - 1;
   localparam int CNT_FIRST = 5;
   localparam int TAIL      = MQ_W + SQ_W;
   localparam int WM        = PH_W + MQ_W;
   localparam int WS        = PM_W + SQ_W;

   typedef struct packed {
      logic [COUNT_BITS-1:0] count;
      logic [HOURS_W-1:0]    hours;
      logic [MIN_W-1:0]      minutes;
      logic [SEC_W-1:0]      seconds;
      logic [FRM_W-1:0]      frames;
   } rsp_type;

   rate_info_type         rinfo;
   logic                  adv;
   logic [COUNT_BITS-1:0] count_s4;

   logic [STAGES-1:0]     v_ff;
   logic                  is_t_ff  [0:LAST];
   logic [COUNT_BITS-1:0] cnt_ff   [CNT_FIRST:LAST];
   logic [PH_W-1:0]       h_rem_ff [0:COUNT_BITS-1];
   logic [COUNT_BITS-1:0] h_nq_ff  [0:COUNT_BITS-1];
   logic [PH_W-1:0]       m_rem_ff [0:MQ_W-1];
   logic [MQ_W-1:0]       m_q_ff   [0:MQ_W-1];
   logic [PM_W-1:0]       s_rem_ff [0:SQ_W-1];
   logic [SQ_W-1:0]       s_q_ff   [0:SQ_W-1];
   logic [HOURS_W-1:0]    hq_ff    [0:TAIL-1];
   logic [MQ_W-1:0]       mq_ff    [0:SQ_W-1];

   rsp_type res, out_ff, skid_ff;
   logic    out_v_ff, skid_v_ff, pop, show;

   tfc_rate_unit u_rate (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_rate_milli_fps (csr_rate_milli_fps),
      .info               (rinfo)
   );

   tfc_count_path #(.COUNT_BITS(COUNT_BITS)) u_count (
      .clock      (clock),
      .adv        (adv),
      .rate       (rinfo.rate),
      .operation  (req_operation),
      .hours_in   (req_hours_in),
      .minutes_in (req_minutes_in),
      .seconds_in (req_seconds_in),
      .frames_in  (req_frames_in),
      .count_out  (count_s4)
   );

   // The pipeline moves whenever the skid register is free.
   assign adv       = !skid_v_ff;
   assign req_ready = adv && !rinfo.busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[STAGES-2:0], req_valid && req_ready};
      end
   end

   genvar gi;
   generate
      for (gi = 0; gi < STAGES; gi++) begin : g_flag
         if (gi == 0) begin : g_first
            always_ff @(posedge clock) begin
               if (adv) is_t_ff[gi] <= (req_operation == OP_TO_FIELDS);
            end
         end else begin : g_next
            always_ff @(posedge clock) begin
               if (adv) is_t_ff[gi] <= is_t_ff[gi-1];
            end
         end
      end

      for (gi = CNT_FIRST; gi < STAGES; gi++) begin : g_cnt
         if (gi == CNT_FIRST) begin : g_first
            always_ff @(posedge clock) begin
               if (adv) cnt_ff[gi] <= count_s4;
            end
         end else begin : g_next
            always_ff @(posedge clock) begin
               if (adv) cnt_ff[gi] <= cnt_ff[gi-1];
            end
         end
      end

      // Hours: one restoring step per stage over the count bits.
      for (gi = 0; gi < COUNT_BITS; gi++) begin : g_hdiv
         logic [PH_W-1:0]       rem_prev;
         logic [COUNT_BITS-1:0] nq_prev;
         logic [PH_W:0]         t;
         logic                  ge;
         if (gi == 0) begin : g_first
            assign rem_prev = '0;
            assign nq_prev  = req_frame_count_in;
         end else begin : g_next
            assign rem_prev = h_rem_ff[gi-1];
            assign nq_prev  = h_nq_ff[gi-1];
         end
         assign t  = {rem_prev, nq_prev[COUNT_BITS-1]};
         assign ge = (t >= {1'b0, rinfo.per_hour});
         always_ff @(posedge clock) begin
            if (adv) begin
               h_rem_ff[gi] <= ge ? PH_W'(t - {1'b0, rinfo.per_hour}) : PH_W'(t);
               h_nq_ff[gi]  <= {nq_prev[COUNT_BITS-2:0], ge};
            end
         end
      end

      // Minutes: the quotient fits in MQ_W bits, so the divisor is aligned
      // to each quotient bit in turn.
      for (gi = 0; gi < MQ_W; gi++) begin : g_mdiv
         localparam int B = MQ_W - 1 - gi;
         logic [PH_W-1:0] rem_prev;
         logic [MQ_W-1:0] q_prev, q_next;
         logic [WM-1:0]   dsh;
         logic            ge;
         if (gi == 0) begin : g_first
            assign rem_prev = h_rem_ff[COUNT_BITS-1];
            assign q_prev   = '0;
         end else begin : g_next
            assign rem_prev = m_rem_ff[gi-1];
            assign q_prev   = m_q_ff[gi-1];
         end
         assign dsh = WM'(rinfo.per_min) << B;
         assign ge  = (WM'(rem_prev) >= dsh);
         always_comb begin
            q_next    = q_prev;
            q_next[B] = ge;
         end
         always_ff @(posedge clock) begin
            if (adv) begin
               m_rem_ff[gi] <= ge ? PH_W'(WM'(rem_prev) - dsh) : rem_prev;
               m_q_ff[gi]   <= q_next;
            end
         end
      end

      // Seconds and frames, the same way with frames per second.
      for (gi = 0; gi < SQ_W; gi++) begin : g_sdiv
         localparam int B = SQ_W - 1 - gi;
         logic [PM_W-1:0] rem_prev;
         logic [SQ_W-1:0] q_prev, q_next;
         logic [WS-1:0]   dsh;
         logic            ge;
         if (gi == 0) begin : g_first
            assign rem_prev = m_rem_ff[MQ_W-1][PM_W-1:0];
            assign q_prev   = '0;
         end else begin : g_next
            assign rem_prev = s_rem_ff[gi-1];
            assign q_prev   = s_q_ff[gi-1];
         end
         assign dsh = WS'(rinfo.per_sec) << B;
         assign ge  = (WS'(rem_prev) >= dsh);
         always_comb begin
            q_next    = q_prev;
            q_next[B] = ge;
         end
         always_ff @(posedge clock) begin
            if (adv) begin
               s_rem_ff[gi] <= ge ? PM_W'(WS'(rem_prev) - dsh) : rem_prev;
               s_q_ff[gi]   <= q_next;
            end
         end
      end

      for (gi = 0; gi < TAIL; gi++) begin : g_hcarry
         if (gi == 0) begin : g_first
            always_ff @(posedge clock) begin
               if (adv) begin
                  if ((h_nq_ff[COUNT_BITS-1] >> HOURS_W) != '0)
                     hq_ff[gi] <= '1;
                  else
                     hq_ff[gi] <= HOURS_W'(h_nq_ff[COUNT_BITS-1]);
               end
            end
         end else begin : g_next
            always_ff @(posedge clock) begin
               if (adv) hq_ff[gi] <= hq_ff[gi-1];
            end
         end
      end

      for (gi = 0; gi < SQ_W; gi++) begin : g_mcarry
         if (gi == 0) begin : g_first
            always_ff @(posedge clock) begin
               if (adv) mq_ff[gi] <= m_q_ff[MQ_W-1];
            end
         end else begin : g_next
            always_ff @(posedge clock) begin
               if (adv) mq_ff[gi] <= mq_ff[gi-1];
            end
         end
      end
   endgenerate

   // A rate below one frame per second leaves the timecode fields at zero.
   always_comb begin
      show          = is_t_ff[LAST] && (rinfo.per_sec != '0);
      res.count     = cnt_ff[LAST];
      res.hours     = show ? hq_ff[TAIL-1] : '0;
      res.minutes   = '0;
      res.seconds   = '0;
      res.frames    = '0;
      if (show) begin
         res.minutes = (mq_ff[SQ_W-1] > MQ_W'(63)) ? '1 : MIN_W'(mq_ff[SQ_W-1]);
         res.seconds = (s_q_ff[SQ_W-1] > SQ_W'(63)) ? '1 : SEC_W'(s_q_ff[SQ_W-1]);
         res.frames  = (s_rem_ff[SQ_W-1] > PM_W'(255)) ? '1 : FRM_W'(s_rem_ff[SQ_W-1]);
      end
   end

   // Output register with a skid stage behind it.
   assign pop = out_v_ff && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (skid_v_ff) begin
         if (pop) skid_v_ff <= 1'b0;
      end else if (v_ff[LAST]) begin
         if (!out_v_ff || pop) out_v_ff  <= 1'b1;
         else                  skid_v_ff <= 1'b1;
      end else if (pop) begin
         out_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_v_ff) begin
         if (pop) out_ff <= skid_ff;
      end else if (v_ff[LAST]) begin
         if (!out_v_ff || pop) out_ff  <= res;
         else                  skid_ff <= res;
      end
   end

   assign rsp_valid           = out_v_ff;
   assign rsp_frame_count_out = out_ff.count;
   assign rsp_hours_out       = out_ff.hours;
   assign rsp_minutes_out     = out_ff.minutes;
   assign rsp_seconds_out     = out_ff.seconds;
   assign rsp_frames_out      = out_ff.frames;

endmodule

[hdl/tfc_checker.sv]
// ----------------------------------------------------------------------------
// tfc_checker
// Port-level checks for the timecode and frame count converter.
// ----------------------------------------------------------------------------
module tfc_checker
   import tfc_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEFAULT
)
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic [OP_W-1:0]       req_operation,
   input logic [COUNT_BITS-1:0] req_frame_count_in,
   input logic [FIELD_W-1:0]    req_hours_in,
   input logic [FIELD_W-1:0]    req_minutes_in,
   input logic [FIELD_W-1:0]    req_seconds_in,
   input logic [FIELD_W-1:0]    req_frames_in,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [COUNT_BITS-1:0] rsp_frame_count_out,
   input logic [HOURS_W-1:0]    rsp_hours_out,
   input logic [MIN_W-1:0]      rsp_minutes_out,
   input logic [SEC_W-1:0]      rsp_seconds_out,
   input logic [FRM_W-1:0]      rsp_frames_out,
   input logic                  csr_valid,
   input logic                  csr_ready,
   input logic [RATE_W-1:0]     csr_rate_milli_fps
);

   // A waiting result stays valid with count, hours and frames held until taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_frame_count_out)
         && $stable(rsp_hours_out) && $stable(rsp_frames_out))
      else $error("result changed while stalled");

   // A result carries either a count or a timecode, never both.
   a_one_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_frame_count_out == '0) || ((rsp_hours_out == '0)
         && (rsp_minutes_out == '0) && (rsp_seconds_out == '0) && (rsp_frames_out == '0)))
      else $error("result mixes count and timecode");

   // Reset empties the output.
   a_reset_empty: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // Requests wait while new divisors are being derived.
   a_rate_block: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready |=> !req_ready && !csr_ready)
      else $error("request taken during rate update");

endmodule

bind timecode_frame_count_converter tfc_checker #(.COUNT_BITS(COUNT_BITS)) u_tfc_checker (.*);

[tb/sv/timecode_frame_count_converter_tb.sv]
// ----------------------------------------------------------------------------
// timecode_frame_count_converter_tb
// Self-checking bench for the timecode and frame count converter. Requests
// are sent with random gaps and responses are taken with random stalls. Each
// response is compared with a predicted timecode or frame count. The run
// covers several frame rates, among them the lowest and highest rates.
// ----------------------------------------------------------------------------
module timecode_frame_count_converter_tb;
   import tfc_pkg::*;

   localparam int CNT_W     = 31;
   localparam int LATENCY   = CNT_W + 14;
   localparam int WDOG_MAX  = 5000;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      logic [CNT_W-1:0]   count;
      logic [HOURS_W-1:0] hours;
      logic [MIN_W-1:0]   minutes;
      logic [SEC_W-1:0]   seconds;
      logic [FRM_W-1:0]   frames;
   } timecode_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [OP_W-1:0] req_operation = '0;
   logic [CNT_W-1:0] req_frame_count_in = '0;
   logic [FIELD_W-1:0] req_hours_in = '0, req_minutes_in = '0;
   logic [FIELD_W-1:0] req_seconds_in = '0, req_frames_in = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [CNT_W-1:0] rsp_frame_count_out;
   logic [HOURS_W-1:0] rsp_hours_out;
   logic [MIN_W-1:0] rsp_minutes_out;
   logic [SEC_W-1:0] rsp_seconds_out;
   logic [FRM_W-1:0] rsp_frames_out;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [RATE_W-1:0] csr_rate_milli_fps = '0;

   timecode_result_type expected_results[$];
   logic [RATE_W-1:0] model_rate;
   int error_count = 0;
   int result_count = 0;
   int rate_writes = 0;
   int idle_pct = 24;
   int hold_off = 0;
   int stall_cycles = 0;
   int wdog = 0;

   timecode_frame_count_converter #(.COUNT_BITS(CNT_W)) uut (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic logic [63:0] bcd_value(input logic [7:0] b);
      return 64'(b[7:4]) * 10 + 64'(b[3:0]);
   endfunction

   function automatic timecode_result_type convert_timecode(
      input logic [1:0] op, input logic [CNT_W-1:0] cnt,
      input logic [7:0] h, input logic [7:0] m, input logic [7:0] s,
      input logic [7:0] f);
      timecode_result_type res;
      logic [63:0] r, ph, pm, ps, hrs, rem, mins, secs, frs, sum;
      logic [63:0] hv, mv, sv, fv;
      res = '0;
      r = 64'(model_rate);
      if (op == OP_TO_FIELDS) begin
         ps = r / 1000;
         if (ps != 0) begin
            ph = (r * 3600) / 1000;
            pm = (r * 60) / 1000;
            hrs = 64'(cnt) / ph;
            rem = 64'(cnt) % ph;
            mins = rem / pm;
            rem = rem % pm;
            secs = rem / ps;
            frs = rem % ps;
            res.hours = (hrs > 64'hFFFFF) ? '1 : hrs[HOURS_W-1:0];
            res.minutes = (mins > 63) ? '1 : mins[MIN_W-1:0];
            res.seconds = (secs > 63) ? '1 : secs[SEC_W-1:0];
            res.frames = (frs > 255) ? '1 : frs[FRM_W-1:0];
         end
      end else if (op == OP_FROM_BIN || op == OP_FROM_BCD) begin
         if (op == OP_FROM_BCD) begin
            hv = bcd_value(h); mv = bcd_value(m); sv = bcd_value(s); fv = bcd_value(f);
         end else begin
            hv = 64'(h); mv = 64'(m); sv = 64'(s); fv = 64'(f);
         end
         sum = (hv * r * 3600) / 1000 + (mv * r * 60) / 1000 + (sv * r) / 1000 + fv;
         res.count = (sum > 64'h7FFFFFFF) ? '1 : sum[CNT_W-1:0];
      end
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("MISMATCH %s: got %0d, expected %0d (result %0d)", what, got, want,
               result_count);
      error_count++;
   endtask

   // Response side: random stalls, an optional long hold-off, and checking.
   always @(posedge clock) begin
      timecode_result_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected response transaction",
                               64'(rsp_frame_count_out), 64'(0));
            end else begin
               want = expected_results.pop_front();
               if (rsp_frame_count_out !== want.count)
                  report_mismatch("frame_count_out", 64'(rsp_frame_count_out),
                                  64'(want.count));
               if (rsp_hours_out !== want.hours)
                  report_mismatch("hours_out", 64'(rsp_hours_out), 64'(want.hours));
               if (rsp_minutes_out !== want.minutes)
                  report_mismatch("minutes_out", 64'(rsp_minutes_out), 64'(want.minutes));
               if (rsp_seconds_out !== want.seconds)
                  report_mismatch("seconds_out", 64'(rsp_seconds_out), 64'(want.seconds));
               if (rsp_frames_out !== want.frames)
                  report_mismatch("frames_out", 64'(rsp_frames_out), 64'(want.frames));
            end
            result_count++;
         end
         if (hold_off > 0) begin
            hold_off <= 0;
            stall_cycles <= 1;
            rsp_ready <= 1'b0;
         end else if (stall_cycles > 0) begin
            stall_cycles <= (stall_cycles >= 300) ? 0 : stall_cycles + 1;
            rsp_ready <= (stall_cycles >= 300);
         end else begin
            rsp_ready <= ($urandom_range(99) >= idle_pct);
         end
      end
   end

   // Watchdog on cycles without any accepted transaction.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         wdog <= 0;
      else
         wdog <= wdog + 1;
      if (wdog >= WDOG_MAX) begin
         $display("Timeout with %0d responses outstanding", expected_results.size());
         $display("Verification failed");
         $finish;
      end
   end

   // Valid stays high after a transaction is taken; the next request either
   // replaces the payload at once or drops valid for its idle cycles.
   task automatic send_request(input logic [1:0] op, input logic [CNT_W-1:0] cnt,
                               input logic [7:0] h, input logic [7:0] m,
                               input logic [7:0] s, input logic [7:0] f);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_frame_count_in <= cnt;
      req_hours_in <= h;
      req_minutes_in <= m;
      req_seconds_in <= s;
      req_frames_in <= f;
      expected_results.push_back(convert_timecode(op, cnt, h, m, s, f));
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   task automatic write_rate(input logic [RATE_W-1:0] rate);
      wait_drained();
      csr_valid <= 1'b1;
      csr_rate_milli_fps <= rate;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      model_rate = rate;
      rate_writes++;
   endtask

   task automatic send_random(input int n);
      logic [1:0] op;
      logic [CNT_W-1:0] cnt;
      repeat (n) begin
         op = 2'($urandom_range(3));
         if (op == OP_UNUSED && $urandom_range(3) != 0) op = OP_TO_FIELDS;
         cnt = $urandom_range(3) == 0 ? CNT_W'($urandom_range(100000))
                                      : CNT_W'($urandom);
         send_request(op, cnt, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      end
   endtask

   task automatic test_directed_corners();
      send_request(OP_TO_FIELDS, '0, 8'h00, 8'h00, 8'h00, 8'h00);
      send_request(OP_TO_FIELDS, '1, 8'h00, 8'h00, 8'h00, 8'h00);
      send_request(OP_TO_FIELDS, 31'd89999, 8'h00, 8'h00, 8'h00, 8'h00);
      send_request(OP_TO_FIELDS, 31'h2AAAAAAA, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      send_request(OP_FROM_BIN, '1, 8'h00, 8'h00, 8'h00, 8'h00);
      send_request(OP_FROM_BIN, '0, 8'd23, 8'd59, 8'd59, 8'd24);
      send_request(OP_FROM_BIN, '0, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      send_request(OP_FROM_BCD, '0, 8'h23, 8'h59, 8'h59, 8'h24);
      send_request(OP_FROM_BCD, '0, 8'hFF, 8'hFA, 8'hAF, 8'h9F);
      send_request(OP_FROM_BCD, '0, 8'h00, 8'h00, 8'h00, 8'h00);
      send_request(OP_UNUSED, '1, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      send_request(OP_UNUSED, 31'h55555555, 8'h55, 8'hAA, 8'h55, 8'hAA);
   endtask

   task automatic test_rate_sweep();
      // Lowest and highest rates, fractional rates and a rate below 1 fps.
      write_rate(RATE_W'(1000));
      test_directed_corners();
      send_random(120);
      write_rate(RATE_W'(240000));
      test_directed_corners();
      send_random(120);
      write_rate(RATE_W'(29970));
      send_random(150);
      write_rate(RATE_W'(1999));
      send_request(OP_TO_FIELDS, 31'd3599, 8'h00, 8'h00, 8'h00, 8'h00);
      send_random(100);
      write_rate(RATE_W'(999));
      send_random(40);
      write_rate(RATE_W'(0));
      send_random(20);
      write_rate('1);
      send_random(60);
   endtask

   task automatic test_back_to_back();
      write_rate(RATE_W'(59940));
      idle_pct = 0;
      send_random(200);
      idle_pct = 24;
   endtask

   task automatic test_receiver_hold_off();
      write_rate(RATE_W'(23976));
      hold_off <= 1;
      send_random(150);
      wait_drained();
   endtask

   task automatic test_random_rates();
      repeat (6) begin
         write_rate(RATE_W'($urandom_range(1000, 240000)));
         send_random(60);
      end
   endtask

   initial begin
      model_rate = RATE_W'(RATE_RESET);
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_corners();
      send_random(60);
      test_rate_sweep();
      test_back_to_back();
      test_receiver_hold_off();
      test_random_rates();
      wait_drained();
      $display("Covered %0d responses over %0d rate settings, all operations,", result_count,
               rate_writes + 1);
      $display("back-to-back traffic and a long response hold-off.");
      if (error_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

[sim.f]
hdl/tfc_pkg.sv
hdl/tfc_rate_unit.sv
hdl/tfc_count_path.sv
hdl/timecode_frame_count_converter.sv
hdl/tfc_checker.sv
tb/sv/timecode_frame_count_converter_tb.sv
